// File: rtl/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg
// Shared types, codes and defaults for the order book bucket snapshot block.
// ----------------------------------------------------------------------------
package obs_pkg;

  // Default sizes handed to the top level
  localparam int NUM_SYMBOLS_DEF    = 16;
  localparam int BOOK_DEPTH_DEF     = 64;
  localparam int MAX_OUT_LEVELS_DEF = 32;

  // Register reset values
  localparam logic [46:0] BUCKET_LENGTH_RST = 47'd1000000000;
  localparam logic [5:0]  OUTPUT_LEVELS_RST = 6'd10;
  localparam logic        BOOK_EVENTS_RST   = 1'b1;
  localparam logic [15:0] SYMBOL_MASK_RST   = 16'hFFFF;

  // Bits of the divider dividend
  localparam int DIV_BITS = 64;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_LEVEL  = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_BUCKET_LENGTH = 2'd0,
    REG_OUTPUT_LEVELS = 2'd1,
    REG_BOOK_EVENTS   = 2'd2,
    REG_SYMBOL_MASK   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_CMP,
    ST_EMIT_SETUP,
    ST_EMIT,
    ST_COMMIT,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         symbol;
    logic signed [63:0] timestamp;
    logic               is_snapshot;
    logic               side;
    logic signed [63:0] price;
    logic [31:0]        quantity;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] bucket_start;
    logic [3:0]         row_symbol;
    logic [4:0]         level_index;
    logic               crossed;
    logic               bid_valid;
    logic signed [63:0] bid_price;
    logic [31:0]        bid_quantity;
    logic               ask_valid;
    logic signed [63:0] ask_price;
    logic [31:0]        ask_quantity;
    logic               last_row;
  } out_item_t;

  // One ladder entry as stored in memory
  typedef struct packed {
    logic [63:0] price;
    logic [31:0] quantity;
  } entry_t;

  // Signed greater-than on two's complement patterns
  function automatic logic sgt(logic [63:0] a, logic [63:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

// File: rtl/obs_ram.sv
// ----------------------------------------------------------------------------
// obs_ram
// Simple dual-port ladder memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module obs_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  obs_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output obs_pkg::entry_t rd_data
);
  import obs_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/obs_div.sv
// ----------------------------------------------------------------------------
// obs_div
// Restoring divider, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module obs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [46:0] divisor,
  output logic        done,
  output logic [46:0] remainder
);
  import obs_pkg::*;

  localparam int CNTW = $clog2(DIV_BITS + 1);

  logic [CNTW-1:0] count;
  logic [63:0]     quo;
  logic [46:0]     dsr;
  logic            running;
  logic [47:0]     trial;

  // Shift in the next dividend bit
  assign trial = {remainder, quo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        count     <= CNTW'(DIV_BITS);
        quo       <= dividend;
        dsr       <= divisor;
        remainder <= '0;
      end else if (running) begin
        // Subtract where the partial remainder allows
        if (trial >= {1'b0, dsr}) begin
          remainder <= 47'(trial - {1'b0, dsr});
        end else begin
          remainder <= trial[46:0];
        end
        quo   <= {quo[62:0], 1'b0};
        count <= count - 1'b1;
        if (count == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/order_book_bucket_snapshot.sv
// ----------------------------------------------------------------------------
// order_book_bucket_snapshot
// Per-symbol price-sorted bid/ask ladders in memory with top-N bucket rows.
// Header: the 64-step bucket divider runs until its done flag, then fix-up,
// compare and commit; closing a bucket adds a setup step, then emits the rows.
// Level update: scans ladder entries one at a time, then decides, shifts
// entries one at a time and writes the entry. Flush: setup, then the rows.
// Each memory port reads one ladder entry per cycle. Results are strobed for
// one cycle; the receiver cannot stall. Reset clears counts and flags at once;
// ladder memories are not cleared.
// ----------------------------------------------------------------------------
module order_book_bucket_snapshot
  import obs_pkg::*;
#(
  parameter int NUM_SYMBOLS    = obs_pkg::NUM_SYMBOLS_DEF,
  parameter int BOOK_DEPTH     = obs_pkg::BOOK_DEPTH_DEF,
  parameter int MAX_OUT_LEVELS = obs_pkg::MAX_OUT_LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  obs_pkg::in_item_t  item,
  output logic               result_valid,
  output obs_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int SW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CW    = $clog2(BOOK_DEPTH + 1);
  localparam int DEPTH = NUM_SYMBOLS * BOOK_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [46:0] bucket_length;
  logic [5:0]  output_levels;
  logic        book_events_enabled;
  logic [15:0] symbol_allow_mask;

  // Per-symbol state
  logic [CW-1:0] bid_cnt  [NUM_SYMBOLS];
  logic [CW-1:0] ask_cnt  [NUM_SYMBOLS];
  logic [63:0]   open_bkt [NUM_SYMBOLS];
  logic          seen     [NUM_SYMBOLS];
  logic [3:0]    cur_sym;
  logic          cur_adm;

  // Working registers
  state_t        state, state_next;
  in_item_t      item_r;
  logic [SW-1:0] sym_r;
  logic [CW-1:0] n_cnt, n_eff, pos, chk, k, rows;
  logic          found, hdr, upd, cr;
  logic [63:0]   b_new, ob;

  // Memory and divider hookup
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, bid_rd, ask_rd, sel_rd;
  logic          div_start, div_done;
  logic [46:0]   div_rem, bl_eff;
  logic [63:0]   dividend;

  // Decode helpers
  logic          accept, cfg_wr, sym_ok;
  logic          scan_eq, scan_before, del;
  logic          down_last, up_last, drop;
  logic [CW-1:0] neff_c, mx_c, rows_c, bc_s, ac_s;
  logic [6:0]    lim_c;
  logic          cr_now, hb, ha;

  function automatic logic [AW-1:0] ent_addr(logic [SW-1:0] s, logic [CW-1:0] i);
    return AW'(s) * AW'(BOOK_DEPTH) + AW'(i);
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state != ST_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign sym_ok  = (32'(item.symbol) < NUM_SYMBOLS);
  assign bl_eff  = (bucket_length == '0) ? 47'd1 : bucket_length;
  assign dividend = item.timestamp[63] ? (~item.timestamp + 64'd1) : item.timestamp;

  // Read back configuration
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[4:3]))
      REG_BUCKET_LENGTH: prdata = 64'(bucket_length);
      REG_OUTPUT_LEVELS: prdata = 64'(output_levels);
      REG_BOOK_EVENTS:   prdata = 64'(book_events_enabled);
      REG_SYMBOL_MASK:   prdata = 64'(symbol_allow_mask);
    endcase
  end

  obs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (bl_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  obs_ram #(.DEPTH(DEPTH), .AW(AW)) u_bid_ram (
    .clk     (clk),
    .wr_en   (wr_en && !item_r.side),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (bid_rd)
  );

  obs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ask_ram (
    .clk     (clk),
    .wr_en   (wr_en && item_r.side),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ask_rd)
  );

  // Ladder scan and shift helpers
  assign sel_rd      = item_r.side ? ask_rd : bid_rd;
  assign scan_eq     = (sel_rd.price == item_r.price);
  assign scan_before = item_r.side ? sgt(sel_rd.price, item_r.price)
                                   : sgt(item_r.price, sel_rd.price);
  assign del         = (item_r.quantity == '0);
  assign drop        = (n_cnt >= CW'(BOOK_DEPTH)) && (pos >= CW'(BOOK_DEPTH));
  assign neff_c      = (n_cnt >= CW'(BOOK_DEPTH)) ? CW'(BOOK_DEPTH - 1) : n_cnt;
  assign down_last   = (chk + 1'b1 == n_cnt);
  assign up_last     = (chk == pos);

  // Emission helpers
  assign bc_s   = bid_cnt[sym_r];
  assign ac_s   = ask_cnt[sym_r];
  assign mx_c   = (bc_s > ac_s) ? bc_s : ac_s;
  assign lim_c  = (output_levels == '0) ? 7'd1 :
                  (32'(output_levels) > MAX_OUT_LEVELS) ? 7'(MAX_OUT_LEVELS) :
                  7'(output_levels);
  assign rows_c = (32'(mx_c) > 32'(lim_c)) ? CW'(lim_c) : mx_c;
  assign hb     = (k < bc_s);
  assign ha     = (k < ac_s);
  assign cr_now = (k == '0) ? ((bc_s != '0) && (ac_s != '0) &&
                               !sgt(ask_rd.price, bid_rd.price)) : cr;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = ent_addr(sym_r, pos);
    wr_data    = '{price: item_r.price, quantity: item_r.quantity};
    rd_addr    = ent_addr(sym_r, '0);
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (item.command)
            CMD_HEADER: begin
              if (book_events_enabled && sym_ok && symbol_allow_mask[item.symbol]) begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            CMD_LEVEL: begin
              if (cur_adm) begin
                rd_addr = ent_addr(SW'(cur_sym), '0);
                if ((item.side ? ask_cnt[SW'(cur_sym)] : bid_cnt[SW'(cur_sym)]) == '0) begin
                  state_next = ST_DECIDE;
                end else begin
                  state_next = ST_SCAN;
                end
              end
            end
            CMD_FLUSH: begin
              if (sym_ok && seen[SW'(item.symbol)]) begin
                state_next = ST_EMIT_SETUP;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: state_next = ST_CMP;
      ST_CMP: begin
        if (seen[sym_r] && sgt(b_new, open_bkt[sym_r])) begin
          state_next = ST_EMIT_SETUP;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_EMIT_SETUP: begin
        rd_addr = ent_addr(sym_r, '0);
        if (rows_c == '0) begin
          state_next = hdr ? ST_COMMIT : ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rd_addr = ent_addr(sym_r, k + 1'b1);
        if (k + 1'b1 == rows) begin
          state_next = hdr ? ST_COMMIT : ST_IDLE;
        end
      end
      ST_COMMIT: state_next = ST_IDLE;
      ST_SCAN: begin
        rd_addr = ent_addr(sym_r, chk + 1'b1);
        if (scan_eq || scan_before || down_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (del) begin
          rd_addr = ent_addr(sym_r, pos + 1'b1);
          state_next = (found && (pos + 1'b1 < n_cnt)) ? ST_SHIFT : ST_IDLE;
        end else if (found) begin
          wr_en      = 1'b1;
          state_next = ST_IDLE;
        end else if (drop) begin
          state_next = ST_IDLE;
        end else if (neff_c > pos) begin
          rd_addr    = ent_addr(sym_r, neff_c - 1'b1);
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_SHIFT: begin
        // Move one entry; delete shifts toward the top, insert away from it
        wr_en   = 1'b1;
        wr_data = sel_rd;
        if (del) begin
          wr_addr = ent_addr(sym_r, chk - 1'b1);
          rd_addr = ent_addr(sym_r, chk + 1'b1);
          if (down_last) begin
            state_next = ST_IDLE;
          end
        end else begin
          wr_addr = ent_addr(sym_r, chk + 1'b1);
          rd_addr = ent_addr(sym_r, chk - 1'b1);
          if (up_last) begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath, per-symbol state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_length       <= BUCKET_LENGTH_RST;
      output_levels       <= OUTPUT_LEVELS_RST;
      book_events_enabled <= BOOK_EVENTS_RST;
      symbol_allow_mask   <= SYMBOL_MASK_RST;
      cur_sym             <= '0;
      cur_adm             <= 1'b0;
      result_valid        <= 1'b0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        bid_cnt[s]  <= '0;
        ask_cnt[s]  <= '0;
        open_bkt[s] <= '0;
        seen[s]     <= 1'b0;
      end
    end else begin
      result_valid <= 1'b0;

      // Take register writes
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[4:3]))
          REG_BUCKET_LENGTH: bucket_length       <= pwdata[46:0];
          REG_OUTPUT_LEVELS: output_levels       <= pwdata[5:0];
          REG_BOOK_EVENTS:   book_events_enabled <= pwdata[0];
          REG_SYMBOL_MASK:   symbol_allow_mask   <= pwdata[15:0];
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_r <= item;
            chk    <= '0;
            k      <= '0;
            priority case (item.command)
              CMD_HEADER: begin
                hdr <= 1'b1;
                if (book_events_enabled && sym_ok && symbol_allow_mask[item.symbol]) begin
                  cur_sym <= item.symbol;
                  cur_adm <= 1'b1;
                  sym_r   <= SW'(item.symbol);
                end else begin
                  cur_adm <= 1'b0;
                end
              end
              CMD_LEVEL: begin
                sym_r <= SW'(cur_sym);
                n_cnt <= item.side ? ask_cnt[SW'(cur_sym)] : bid_cnt[SW'(cur_sym)];
                found <= 1'b0;
                pos   <= '0;
              end
              CMD_FLUSH: begin
                hdr   <= 1'b0;
                sym_r <= SW'(item.symbol);
                ob    <= open_bkt[SW'(item.symbol)];
              end
              default: hdr <= 1'b0;
            endcase
          end
        end
        ST_DIV: ;
        ST_FIX: begin
          // Floor toward minus infinity for negative times
          if (item_r.timestamp[63]) begin
            b_new <= item_r.timestamp - ((div_rem != '0) ? 64'(bl_eff - div_rem) : 64'd0);
          end else begin
            b_new <= item_r.timestamp - 64'(div_rem);
          end
        end
        ST_CMP: begin
          ob  <= open_bkt[sym_r];
          upd <= !seen[sym_r] || sgt(b_new, open_bkt[sym_r]);
        end
        ST_EMIT_SETUP: rows <= rows_c;
        ST_EMIT: begin
          // Drive one row
          cr           <= cr_now;
          k            <= k + 1'b1;
          result_valid <= 1'b1;
          result       <= '{
            bucket_start: ob,
            row_symbol:   4'(sym_r),
            level_index:  5'(k),
            crossed:      cr_now,
            bid_valid:    hb,
            bid_price:    hb ? bid_rd.price : 64'd0,
            bid_quantity: hb ? bid_rd.quantity : 32'd0,
            ask_valid:    ha,
            ask_price:    ha ? ask_rd.price : 64'd0,
            ask_quantity: ha ? ask_rd.quantity : 32'd0,
            last_row:     (k + 1'b1 == rows)
          };
        end
        ST_COMMIT: begin
          if (upd) begin
            open_bkt[sym_r] <= b_new;
            seen[sym_r]     <= 1'b1;
          end
          if (item_r.is_snapshot) begin
            bid_cnt[sym_r] <= '0;
            ask_cnt[sym_r] <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_eq || scan_before) begin
            pos   <= chk;
            found <= scan_eq;
          end else if (down_last) begin
            pos <= n_cnt;
          end else begin
            chk <= chk + 1'b1;
          end
        end
        ST_DECIDE: begin
          n_eff <= neff_c;
          if (del) begin
            chk <= pos + 1'b1;
            if (found && !(pos + 1'b1 < n_cnt)) begin
              if (item_r.side) ask_cnt[sym_r] <= n_cnt - 1'b1;
              else             bid_cnt[sym_r] <= n_cnt - 1'b1;
            end
          end else begin
            chk <= neff_c - 1'b1;
          end
        end
        ST_SHIFT: begin
          if (del) begin
            chk <= chk + 1'b1;
            if (down_last) begin
              if (item_r.side) ask_cnt[sym_r] <= n_cnt - 1'b1;
              else             bid_cnt[sym_r] <= n_cnt - 1'b1;
            end
          end else begin
            chk <= chk - 1'b1;
          end
        end
        ST_WRITE: begin
          if (item_r.side) ask_cnt[sym_r] <= n_eff + 1'b1;
          else             bid_cnt[sym_r] <= n_eff + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
